// ===== hw/rtl/wildcard_pattern_matcher_defines.svh =====
// Assertion macros shared by the wildcard pattern matcher RTL.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wpm_pkg.sv =====
// Package with types and constants for the wildcard pattern matcher.
package wpm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load;
        logic scan;
        logic commit;
        logic restore;
        logic report;
    } wpm_cmd_t;

endpackage

// ===== hw/rtl/wpm_ctrl.sv =====
// Controller state machine for the wildcard pattern matcher.
module wpm_ctrl
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_stall,
    input  logic [1:0]                                        kind,
    output logic                                              out_valid,
    input  logic                                              out_stall,
    output wpm_cmd_t                                          cmd,
    output logic [$clog2($clog2(PATTERN_MAX + 1)) - 1:0]      lvl
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int LVL_W = $clog2(LEN_W);
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEN_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESTORE
    } state_t;

    state_t           state_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             out_valid_reg;
    logic             out_busy;
    logic             accept;
    kind_t            kind_in;

    assign kind_in  = kind_t'(kind);
    assign out_busy = out_valid_reg && out_stall;
    assign in_stall = (state_reg != ST_IDLE) || ((kind_in == KIND_END) && out_busy);
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign lvl       = lvl_reg;

    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            unique case (kind_in)
                KIND_CLEAR:  cmd.clear  = 1'b1;
                KIND_APPEND: cmd.append = 1'b1;
                KIND_TEXT:   cmd.load   = 1'b1;
                KIND_END:    cmd.report = 1'b1;
            endcase
        end
        if (state_reg == ST_SCAN)
        begin
            cmd.scan   = 1'b1;
            cmd.commit = (lvl_reg == LAST_LVL);
        end
        if (state_reg == ST_RESTORE)
        begin
            cmd.restore = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.report)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        lvl_reg   <= '0;
                        state_reg <= (kind_in == KIND_TEXT) ? ST_SCAN : ST_RESTORE;
                    end
                end
                ST_SCAN:
                begin
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    if (lvl_reg == LAST_LVL)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RESTORE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/wpm_datapath.sv =====
// Datapath of the wildcard pattern matcher: pattern cells, match vector, star scan.
module wpm_datapath
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [7:0]                                        symbol,
    input  wpm_cmd_t                                          cmd,
    input  logic [$clog2($clog2(PATTERN_MAX + 1)) - 1:0]      lvl,
    output logic                                              matched,
    output logic                                              pattern_overflow
);

    localparam int NV    = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(NV);
    localparam int IDX_W = $clog2(PATTERN_MAX);

    logic [7:0]       store_reg [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] lsc_reg;
    logic             only_stars_reg;
    logic             ovf_reg;
    logic [NV-1:0]    vec_reg;
    logic [NV-1:0]    g_reg;
    logic [NV-1:0]    p_reg;
    logic             matched_reg;
    logic             ovf_out_reg;

    logic [NV-1:0]    g_init;
    logic [NV-1:0]    p_init;
    logic [NV-1:0]    g_step;
    logic [NV-1:0]    p_step;
    logic [NV-1:0]    vec_rest;
    logic [NV-1:0]    last_sel;
    logic [LEN_W-1:0] shift_amt;
    logic             full;

    assign full = (len_reg == LEN_W'(PATTERN_MAX));

    // Per-cell generate/propagate terms for one text byte
    always_comb
    begin
        g_init[0]   = 1'b0;
        p_init[0]   = 1'b0;
        vec_rest[0] = 1'b1;
        last_sel[0] = (len_reg == '0);
        for (int j = 1; j < NV; j++)
        begin
            vec_rest[j] = (LEN_W'(j) <= lsc_reg);
            last_sel[j] = (LEN_W'(j) == len_reg);
            if (LEN_W'(j) <= len_reg)
            begin
                if (store_reg[j-1] == STAR_BYTE)
                begin
                    g_init[j] = vec_reg[j];
                    p_init[j] = 1'b1;
                end
                else
                begin
                    g_init[j] = vec_reg[j-1] &&
                                ((store_reg[j-1] == ANY_BYTE) || (store_reg[j-1] == symbol));
                    p_init[j] = 1'b0;
                end
            end
            else
            begin
                g_init[j] = vec_reg[j];
                p_init[j] = 1'b0;
            end
        end
    end

    // One prefix level of the star ripple per cycle
    assign shift_amt = LEN_W'(1) << lvl;
    assign g_step    = g_reg | (p_reg & (g_reg << shift_amt));
    assign p_step    = p_reg & (p_reg << shift_amt);

    // Pattern bytes: written once per append that finds room, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= symbol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            g_reg <= g_init;
            p_reg <= p_init;
        end
        else if (cmd.scan)
        begin
            g_reg <= g_step;
            p_reg <= p_step;
        end
        if (cmd.report)
        begin
            matched_reg <= |(vec_reg & last_sel);
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            lsc_reg        <= '0;
            only_stars_reg <= 1'b1;
            ovf_reg        <= 1'b0;
            vec_reg        <= NV'(1);
        end
        else
        begin
            if (cmd.clear)
            begin
                len_reg        <= '0;
                lsc_reg        <= '0;
                only_stars_reg <= 1'b1;
                ovf_reg        <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_reg <= len_reg + LEN_W'(1);
                    if (only_stars_reg && (symbol == STAR_BYTE))
                    begin
                        lsc_reg <= lsc_reg + LEN_W'(1);
                    end
                    else
                    begin
                        only_stars_reg <= 1'b0;
                    end
                end
            end
            if (cmd.restore)
            begin
                vec_reg <= vec_rest;
            end
            else if (cmd.commit)
            begin
                vec_reg <= g_step;
            end
        end
    end

    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

endmodule

// ===== hw/rtl/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: controller, datapath and checks.
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -------------------------
//  input     in         in_valid / in_stall   kind[1:0], symbol[7:0]
//  output    out        out_valid / out_stall matched, pattern_overflow
//
// A text byte holds off further input while the star ripple runs as a registered
// prefix scan, one level per cycle.
// Clear, append and end items pass through the transfer, then a vector restore.
// Reset sets control state, pattern length, flags and the match vector to start values; the
// pattern store holds no reset value and needs no clearing pass.
// An end item stalls while an earlier result still waits on out_stall; other
// items keep flowing past a held result.
`include "wildcard_pattern_matcher_defines.svh"

module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int LVL_W = $clog2(LEN_W);

    // Command bundle and scan level from controller to datapath
    wpm_cmd_t         cmd;
    logic [LVL_W-1:0] lvl;
    logic             in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // Controller: sequences each item and owns the output valid
    wpm_ctrl #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .lvl       (lvl)
    );

    // Datapath: pattern cells, match vector and result registers
    wpm_datapath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .symbol           (symbol),
        .cmd              (cmd),
        .lvl              (lvl),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    // Every accepted item leaves the block busy, so no item is accepted back to back
    `WPM_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "item accepted back to back")
    // An accepted end item shows a result in the next cycle
    `WPM_ASSERT_NEXT(a_end_gives_result, in_xfer && (kind == KIND_END), out_valid, "end item lost its result")
    // A result held by the consumer is never overwritten by a new end item
    `WPM_ASSERT_NOW(a_no_overwrite, out_valid && out_stall, !(in_xfer && (kind == KIND_END)), "held result overwritten")

endmodule
